### rtl/core/cptr_pkg.sv
// cptr_pkg: shared widths, constants and types for the capture period to rpm block
// no dependencies; imported by every module under rtl/core
package cptr_pkg;

    localparam int CLK_W  = 27;
    localparam int RPM_W  = 33;
    localparam int STEP_W = $clog2(RPM_W);

    localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(16000000);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic measured;
        logic zero;
    } t_flags;

endpackage

### rtl/core/cptr_front.sv
// cptr_front: takes timestamp requests, keeps the previous edge and forms the tick count
// depends on cptr_pkg; feeds cptr_queue
module cptr_front #(
    parameter int COUNTER_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [COUNTER_BITS-1:0] i_capture_value,
    input  logic                    i_q_full,
    output logic                    o_push,
    output logic [COUNTER_BITS-1:0] o_ticks,
    output cptr_pkg::t_flags        o_flags
);
    import cptr_pkg::*;

    logic [COUNTER_BITS-1:0] r_last_capture;
    logic                    r_have_edge;
    logic [COUNTER_BITS-1:0] diff;
    logic [COUNTER_BITS-1:0] wrap;
    logic [COUNTER_BITS-1:0] ticks;

    assign o_stall = i_q_full;
    assign o_push  = i_valid & ~i_q_full;

    always_comb begin
        diff = r_last_capture - i_capture_value;
        // wrap form: all-ones minus new plus old
        wrap = ~i_capture_value + r_last_capture;
        if (!r_have_edge) begin
            ticks = '0;
        end else if (r_last_capture > i_capture_value) begin
            ticks = diff;
        end else begin
            ticks = wrap;
        end
    end

    assign o_ticks          = ticks;
    assign o_flags.measured = r_have_edge;
    assign o_flags.zero     = r_have_edge & (ticks == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_capture <= '0;
            r_have_edge    <= 1'b0;
        end else if (o_push) begin
            r_last_capture <= i_capture_value;
            r_have_edge    <= 1'b1;
        end
    end

endmodule

### rtl/core/cptr_queue.sv
// cptr_queue: short fifo of tick counts and flags between front and back
// depends on cptr_pkg
module cptr_queue #(
    parameter int COUNTER_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [COUNTER_BITS-1:0] i_ticks,
    input  cptr_pkg::t_flags        i_flags,
    input  logic                    i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output logic [COUNTER_BITS-1:0] o_ticks,
    output cptr_pkg::t_flags        o_flags
);
    import cptr_pkg::*;

    logic [COUNTER_BITS-1:0] r_ticks [Q_DEPTH];
    t_flags                  r_flags [Q_DEPTH];
    logic [Q_AW-1:0]         r_wr_ptr;
    logic [Q_AW-1:0]         r_rd_ptr;
    logic [Q_CW-1:0]         r_count;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_ticks = r_ticks[r_rd_ptr];
    assign o_flags = r_flags[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ticks[r_wr_ptr] <= i_ticks;
            r_flags[r_wr_ptr] <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/cptr_back.sv
// cptr_back: clock register, radix-2 restoring divider and output register
// depends on cptr_pkg; drains cptr_queue
module cptr_back #(
    parameter int COUNTER_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cptr_pkg::CLK_W-1:0] i_cfg_data,
    input  logic                       i_q_empty,
    input  logic [COUNTER_BITS-1:0]    i_q_ticks,
    input  cptr_pkg::t_flags           i_q_flags,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [cptr_pkg::RPM_W-1:0] o_rpm,
    output logic [COUNTER_BITS-1:0]    o_period_ticks,
    output logic                       o_measure_valid,
    output logic                       o_zero_period
);
    import cptr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [COUNTER_BITS-1:0] r_rem, n_rem;
    logic [RPM_W-1:0]        r_quo, n_quo;
    logic [COUNTER_BITS-1:0] r_div, n_div;
    t_flags                  r_flags, n_flags;
    logic                    r_out_valid, n_out_valid;
    logic [RPM_W-1:0]        r_rpm, n_rpm;
    logic [COUNTER_BITS-1:0] r_ticks_out, n_ticks_out;
    logic                    r_mv, n_mv;
    logic                    r_zp, n_zp;
    logic [CLK_W-1:0]        r_clock_hz;

    logic                    out_take;
    logic [RPM_W-1:0]        dividend;
    logic [COUNTER_BITS:0]   trial;
    logic [COUNTER_BITS:0]   sub;
    logic                    ge;

    assign out_take = r_out_valid & ~i_stall;
    assign o_pop    = (r_state == S_IDLE) & ~i_q_empty;

    // clock_hz * 60 as (c << 6) - (c << 2)
    assign dividend = {r_clock_hz, 6'b0} - {4'b0, r_clock_hz, 2'b0};

    assign trial = {r_rem, r_quo[RPM_W-1]};
    assign sub   = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div       = r_div;
        n_flags     = r_flags;
        n_out_valid = r_out_valid & ~out_take;
        n_rpm       = r_rpm;
        n_ticks_out = r_ticks_out;
        n_mv        = r_mv;
        n_zp        = r_zp;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_div   = i_q_ticks;
                    n_flags = i_q_flags;
                    n_rem   = '0;
                    n_step  = '0;
                    if (i_q_flags.measured && !i_q_flags.zero) begin
                        n_quo   = dividend;
                        n_state = S_DIV;
                    end else begin
                        n_quo   = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                n_rem = ge ? sub[COUNTER_BITS-1:0] : trial[COUNTER_BITS-1:0];
                n_quo = {r_quo[RPM_W-2:0], ge};
                if (r_step == STEP_W'(RPM_W - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || out_take) begin
                    n_rpm       = r_quo;
                    n_ticks_out = r_div;
                    n_mv        = r_flags.measured;
                    n_zp        = r_flags.zero;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_clock_hz  <= CLOCK_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_clock_hz <= i_cfg_data;
            end
        end
        r_step      <= n_step;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_div       <= n_div;
        r_flags     <= n_flags;
        r_rpm       <= n_rpm;
        r_ticks_out <= n_ticks_out;
        r_mv        <= n_mv;
        r_zp        <= n_zp;
    end

    assign o_valid         = r_out_valid;
    assign o_rpm           = r_rpm;
    assign o_period_ticks  = r_ticks_out;
    assign o_measure_valid = r_mv;
    assign o_zero_period   = r_zp;

endmodule

### rtl/core/capture_period_to_rpm.sv
// capture_period_to_rpm: tachometer top level, front, queue and divider back end
// depends on cptr_pkg, cptr_front, cptr_queue, cptr_back
//
//   channel   direction   handshake                 payload
//   input     in          i_in_valid / o_in_stall   i_capture_value
//   output    out         o_out_valid / i_out_stall o_rpm, o_period_ticks,
//                                                   o_measure_valid, o_zero_period
//   config    in          i_cfg_we                  i_cfg_data (clock_hz)
//
// a measured period is loaded into the back end, runs 33 divider steps (one
// quotient bit a cycle) and then fills the output register once it is free.
// the first edge and a zero period skip the divider: load, then output register.
// the front takes a request each cycle until the 2-entry queue fills.
// reset is synchronous, active low; clock_hz returns to 16000000.
module capture_period_to_rpm #(
    parameter int COUNTER_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cptr_pkg::CLK_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [COUNTER_BITS-1:0]    i_capture_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [cptr_pkg::RPM_W-1:0] o_rpm,
    output logic [COUNTER_BITS-1:0]    o_period_ticks,
    output logic                       o_measure_valid,
    output logic                       o_zero_period
);
    import cptr_pkg::*;

    logic                    push;
    logic                    pop;
    logic                    q_full;
    logic                    q_empty;
    logic [COUNTER_BITS-1:0] f_ticks;
    logic [COUNTER_BITS-1:0] q_ticks;
    t_flags                  f_flags;
    t_flags                  q_flags;

    cptr_front #(.COUNTER_BITS(COUNTER_BITS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_capture_value (i_capture_value),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_ticks         (f_ticks),
        .o_flags         (f_flags)
    );

    cptr_queue #(.COUNTER_BITS(COUNTER_BITS)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ticks (f_ticks),
        .i_flags (f_flags),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_ticks (q_ticks),
        .o_flags (q_flags)
    );

    cptr_back #(.COUNTER_BITS(COUNTER_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_q_empty       (q_empty),
        .i_q_ticks       (q_ticks),
        .i_q_flags       (q_flags),
        .o_pop           (pop),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_rpm           (o_rpm),
        .o_period_ticks  (o_period_ticks),
        .o_measure_valid (o_measure_valid),
        .o_zero_period   (o_zero_period)
    );

endmodule
